// File: hw/rtl/tkpbd_pkg.sv
// types, constants and key compare shared by the dispatcher modules
package tkpbd_pkg;

    localparam int TAG_W   = 16;
    localparam int UNITS_W = 10;
    localparam int URG_W   = 2;
    localparam int KIND_W  = 2;
    localparam int COST_W  = 26;
    localparam int GRAMS_W = 26;
    localparam int REV_W   = 48;
    localparam int CARB_W  = 40;
    localparam int PORTS_W = 7;
    localparam int PRICE_W = 16;
    localparam int CFG_W   = 1;

    localparam logic [PORTS_W-1:0] PORTS_RST = 7'd10;
    localparam logic [PRICE_W-1:0] PRICE_RST = 16'd800;

    localparam logic [CFG_W-1:0] CFG_PORTS = 1'b0;
    localparam logic [CFG_W-1:0] CFG_PRICE = 1'b1;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_BATCH = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [UNITS_W-1:0] units;
        logic [URG_W-1:0]   urg;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_chain_ctl;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic               status;
        t_entry             entry;
        logic [COST_W-1:0]  cost;
        logic [GRAMS_W-1:0] grams;
        logic               last;
    } t_s1;

    // strict order on the two keys; ties keep arrival order in the chain
    function automatic logic key_less(input t_entry a, input t_entry b);
        logic res;
        if (a.urg != b.urg) begin
            res = a.urg < b.urg;
        end else begin
            res = a.units < b.units;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/two_key_priority_batch_dispatcher.sv
// top level: command port, sorted cell chain, batch sequencer and result stage
// an add's acknowledge passes r_s1, then the result stage; no new request while r_s1 is valid
// a batch of n dispatches pops the head cell once a cycle; each pop passes r_s1 and
// the result stage, giving one result per cycle; empty batch as an add
// the receiver cannot stall; results show for exactly one cycle on o_result_valid
// synchronous active-low reset empties the queue, clears totals, ports 10, price 800
module two_key_priority_batch_dispatcher #(
    parameter int QUEUE_DEPTH           = 64,
    parameter int BATCH_CAP             = 20,
    parameter int CARBON_GRAMS_PER_UNIT = 920
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_req_type,
    input  logic [tkpbd_pkg::TAG_W-1:0]    i_vehicle_tag,
    input  logic [tkpbd_pkg::UNITS_W-1:0]  i_battery_capacity,
    input  logic [tkpbd_pkg::UNITS_W-1:0]  i_present_charge,
    input  logic [tkpbd_pkg::URG_W-1:0]    i_urgency,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tkpbd_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_result_valid,
    output logic [tkpbd_pkg::KIND_W-1:0]   o_kind,
    output logic                           o_status,
    output logic [tkpbd_pkg::TAG_W-1:0]    o_out_tag,
    output logic [tkpbd_pkg::UNITS_W-1:0]  o_units,
    output logic [tkpbd_pkg::URG_W-1:0]    o_out_urgency,
    output logic [tkpbd_pkg::COST_W-1:0]   o_cost,
    output logic [tkpbd_pkg::REV_W-1:0]    o_revenue_total,
    output logic [tkpbd_pkg::CARB_W-1:0]   o_carbon_total,
    output logic                           o_last
);
    import tkpbd_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BC_W  = $clog2(BATCH_CAP + 1);
    localparam int CMP_W = (OCC_W > PORTS_W) ? OCC_W : PORTS_W;

    typedef enum logic {ST_IDLE, ST_POP} t_state;

    t_state              r_state, n_state;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [BC_W-1:0]     r_left, n_left;
    t_s1                 r_s1, n_s1;
    logic [PORTS_W-1:0]  r_ports;
    logic [PRICE_W-1:0]  r_price;

    logic                w_accept;
    logic                w_full;
    t_chain_ctl          w_ctl;
    t_entry              w_new;
    t_entry              w_entry [QUEUE_DEPTH];
    logic                w_beat  [QUEUE_DEPTH];
    logic [UNITS_W-1:0]  w_add_units;
    logic [UNITS_W-1:0]  w_units;
    logic [COST_W-1:0]   w_cost;
    logic [GRAMS_W-1:0]  w_grams;
    logic [CMP_W-1:0]    w_cap_n;
    logic [CMP_W-1:0]    w_n;

    assign busy        = (r_state != ST_IDLE) || r_s1.valid;
    assign w_accept    = start && !busy;
    assign w_full      = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign o_cfg_ready = 1'b1;

    assign w_add_units = (i_battery_capacity > i_present_charge) ?
                         (i_battery_capacity - i_present_charge) : '0;
    assign w_new.tag   = i_vehicle_tag;
    assign w_new.units = w_add_units;
    assign w_new.urg   = i_urgency;

    assign w_ctl.insert = w_accept && (i_req_type == REQ_ADD) && !w_full;
    assign w_ctl.pop    = (r_state == ST_POP);

    // entries in batch: min(ports, cap, occupancy)
    assign w_cap_n = (CMP_W'(r_ports) < CMP_W'(BATCH_CAP)) ? CMP_W'(r_ports)
                                                          : CMP_W'(BATCH_CAP);
    assign w_n     = (CMP_W'(r_occ) < w_cap_n) ? CMP_W'(r_occ) : w_cap_n;

    assign w_units = w_ctl.pop ? w_entry[0].units : w_add_units;
    assign w_cost  = COST_W'(w_units) * COST_W'(r_price);
    assign w_grams = GRAMS_W'(w_units) * GRAMS_W'(CARBON_GRAMS_PER_UNIT);

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_entry w_prev_entry;
        logic   w_prev_beat;
        t_entry w_next_entry;

        if (gi == 0) begin : g_head
            assign w_prev_entry = w_new;
            assign w_prev_beat  = 1'b0;
        end else begin : g_body
            assign w_prev_entry = w_entry[gi-1];
            assign w_prev_beat  = w_beat[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next_entry = w_entry[gi];
        end else begin : g_mid
            assign w_next_entry = w_entry[gi+1];
        end

        tkpbd_cell #(
            .IDX   (gi),
            .OCC_W (OCC_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (r_occ),
            .i_new        (w_new),
            .i_prev_entry (w_prev_entry),
            .i_prev_beat  (w_prev_beat),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[gi]),
            .o_beat       (w_beat[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        n_occ   = r_occ;
        n_left  = r_left;
        n_s1    = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_ADD) begin
                        n_s1.valid  = 1'b1;
                        n_s1.kind   = KIND_ACK;
                        n_s1.status = w_full ? STAT_FULL : STAT_OK;
                        n_s1.entry  = w_new;
                        n_s1.cost   = w_cost;
                        n_s1.grams  = w_grams;
                        n_s1.last   = 1'b1;
                        if (!w_full) begin
                            n_occ = r_occ + 1'b1;
                        end
                    end else if (w_n == '0) begin
                        n_s1.valid = 1'b1;
                        n_s1.kind  = KIND_EMPTY;
                        n_s1.last  = 1'b1;
                    end else begin
                        n_left  = w_n[BC_W-1:0];
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                n_s1.valid  = 1'b1;
                n_s1.kind   = KIND_DISP;
                n_s1.status = STAT_OK;
                n_s1.entry  = w_entry[0];
                n_s1.cost   = w_cost;
                n_s1.grams  = w_grams;
                n_s1.last   = (r_left == BC_W'(1));
                n_occ       = r_occ - 1'b1;
                n_left      = r_left - 1'b1;
                if (r_left == BC_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_occ   <= '0;
            r_left  <= '0;
            r_s1    <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_left  <= n_left;
            r_s1    <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ports <= PORTS_RST;
            r_price <= PRICE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PORTS: r_ports <= i_cfg_data[PORTS_W-1:0];
                CFG_PRICE: r_price <= i_cfg_data[PRICE_W-1:0];
                default:   r_ports <= r_ports;
            endcase
        end
    end

    tkpbd_acct u_acct (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s1            (r_s1),
        .o_result_valid  (o_result_valid),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_out_tag       (o_out_tag),
        .o_units         (o_units),
        .o_out_urgency   (o_out_urgency),
        .o_cost          (o_cost),
        .o_revenue_total (o_revenue_total),
        .o_carbon_total  (o_carbon_total),
        .o_last          (o_last)
    );

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> (r_occ != '0) && (r_left != '0))
        else $error("pop from empty queue or empty batch");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |=> o_result_valid)
        else $error("staged request produced no result");

    a_no_accept_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP) |-> busy)
        else $error("request port open during a batch");
`endif

endmodule

// File: hw/rtl/tkpbd_cell.sv
// one cell of the sorted request chain
module tkpbd_cell #(
    parameter int IDX   = 0,
    parameter int OCC_W = 7
) (
    input  logic                 i_clk,
    input  tkpbd_pkg::t_chain_ctl i_ctl,
    input  logic [OCC_W-1:0]     i_occ,
    input  tkpbd_pkg::t_entry    i_new,
    input  tkpbd_pkg::t_entry    i_prev_entry,
    input  logic                 i_prev_beat,
    input  tkpbd_pkg::t_entry    i_next_entry,
    output tkpbd_pkg::t_entry    o_entry,
    output logic                 o_beat
);
    import tkpbd_pkg::*;

    t_entry r_entry;

    // empty cell or new request ranks ahead of the one held here
    assign o_beat  = (i_occ <= OCC_W'(IDX)) || key_less(i_new, r_entry);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_entry <= i_next_entry;
        end else if (i_ctl.insert && o_beat) begin
            r_entry <= i_prev_beat ? i_prev_entry : i_new;
        end
    end

endmodule

// File: hw/rtl/tkpbd_acct.sv
// result stage: saturating revenue and carbon totals and result registers
module tkpbd_acct (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tkpbd_pkg::t_s1                 i_s1,
    output logic                           o_result_valid,
    output logic [tkpbd_pkg::KIND_W-1:0]   o_kind,
    output logic                           o_status,
    output logic [tkpbd_pkg::TAG_W-1:0]    o_out_tag,
    output logic [tkpbd_pkg::UNITS_W-1:0]  o_units,
    output logic [tkpbd_pkg::URG_W-1:0]    o_out_urgency,
    output logic [tkpbd_pkg::COST_W-1:0]   o_cost,
    output logic [tkpbd_pkg::REV_W-1:0]    o_revenue_total,
    output logic [tkpbd_pkg::CARB_W-1:0]   o_carbon_total,
    output logic                           o_last
);
    import tkpbd_pkg::*;

    logic                r_valid;
    logic [KIND_W-1:0]   r_kind;
    logic                r_status;
    t_entry              r_entry;
    logic [COST_W-1:0]   r_cost;
    logic                r_last;
    logic [REV_W-1:0]    r_rev;
    logic [CARB_W-1:0]   r_carb;

    logic [REV_W:0]      w_rev_sum;
    logic [CARB_W:0]     w_carb_sum;
    logic [REV_W-1:0]    n_rev;
    logic [CARB_W-1:0]   n_carb;

    assign w_rev_sum  = {1'b0, r_rev} + (REV_W + 1)'(i_s1.cost);
    assign w_carb_sum = {1'b0, r_carb} + (CARB_W + 1)'(i_s1.grams);

    always_comb begin
        n_rev  = r_rev;
        n_carb = r_carb;
        if (i_s1.valid && i_s1.kind == KIND_DISP) begin
            n_rev  = w_rev_sum[REV_W]   ? {REV_W{1'b1}}  : w_rev_sum[REV_W-1:0];
            n_carb = w_carb_sum[CARB_W] ? {CARB_W{1'b1}} : w_carb_sum[CARB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rev   <= '0;
            r_carb  <= '0;
        end else begin
            r_valid <= i_s1.valid;
            r_rev   <= n_rev;
            r_carb  <= n_carb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1.valid) begin
            r_kind   <= i_s1.kind;
            r_status <= i_s1.status;
            r_entry  <= i_s1.entry;
            r_cost   <= i_s1.cost;
            r_last   <= i_s1.last;
        end
    end

    assign o_result_valid  = r_valid;
    assign o_kind          = r_kind;
    assign o_status        = r_status;
    assign o_out_tag       = r_entry.tag;
    assign o_units         = r_entry.units;
    assign o_out_urgency   = r_entry.urg;
    assign o_cost          = r_cost;
    assign o_revenue_total = r_rev;
    assign o_carbon_total  = r_carb;
    assign o_last          = r_last;

endmodule
